### rtl/max_ones_run_with_flips_unit_assert.svh
// Assertion macros used by the max-ones-run top level.
`ifndef MAX_ONES_RUN_WITH_FLIPS_UNIT_ASSERT_SVH
`define MAX_ONES_RUN_WITH_FLIPS_UNIT_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define MORF_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("morf: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define MORF_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("morf: next-cycle check failed");

`endif

### rtl/morf_pkg.sv
// Package: constants for the max-ones-run unit.
`timescale 1ns / 1ps
`default_nettype none
package morf_pkg;

  // Parameter defaults
  localparam int FLIP_LIMIT_DEF = 15;
  localparam int INDEX_BITS_DEF = 16;

  // Field widths
  localparam int CFG_W  = 4;
  localparam int OUT_W  = 16;
  localparam int OUT_MAX = 65535;

  // Reset value of the max_flips register
  localparam logic [CFG_W-1:0] MAX_FLIPS_RST = 4'd1;

endpackage : morf_pkg
`default_nettype wire

### rtl/morf_cell.sv
// One cell of the zero-position chain: holds a position, takes its neighbour's on shift.
`timescale 1ns / 1ps
`default_nettype none
module morf_cell #(
  parameter int W = 16
) (
  input  wire logic         clk_i,
  input  wire logic         shift_i,
  input  wire logic [W-1:0] d_i,
  output logic      [W-1:0] q_o
);

  logic [W-1:0] pos_q;

  // payload only, no reset needed
  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      pos_q <= d_i;
    end
  end

  assign q_o = pos_q;

endmodule : morf_cell
`default_nettype wire

### rtl/morf_chain.sv
// Chain of cells holding zero positions, newest in cell 0, with one selectable tap.
`timescale 1ns / 1ps
`default_nettype none
module morf_chain #(
  parameter int DEPTH = 15,
  parameter int W     = 16,
  localparam int SELW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic            clk_i,
  input  wire logic            shift_i,
  input  wire logic [W-1:0]    din_i,
  input  wire logic [SELW-1:0] tap_sel_i,
  output logic      [W-1:0]    tap_o
);

  logic [W-1:0] cell_q [DEPTH];

  // newest zero enters cell 0, older ones move one cell along
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    if (i == 0) begin : g_head
      morf_cell #(.W(W)) u_cell (
        .clk_i  (clk_i),
        .shift_i(shift_i),
        .d_i    (din_i),
        .q_o    (cell_q[i])
      );
    end else begin : g_body
      morf_cell #(.W(W)) u_cell (
        .clk_i  (clk_i),
        .shift_i(shift_i),
        .d_i    (cell_q[i-1]),
        .q_o    (cell_q[i])
      );
    end
  end

  // tap: the k-th newest stored zero
  always_comb begin
    tap_o = cell_q[0];
    for (int i = 0; i < DEPTH; i++) begin
      if (tap_sel_i == SELW'(i)) begin
        tap_o = cell_q[i];
      end
    end
  end

endmodule : morf_chain
`default_nettype wire

### rtl/max_ones_run_with_flips_unit.sv
// Top level: longest run of ones with up to max_flips zeros flipped, one bit per word.
//
// Input channel s_axis: one word per bit; tdata[0] is the bit, tlast closes the stream.
// Output channel m_axis: one word per input word; tdata holds best and current window
// length, tlast marks the answer to the closing bit, tuser the sticky overflow flag.
// Config channel cfg: writes max_flips (4 bits, reset 1); write only while idle.
// Latency: the result word is valid the cycle after its input word is taken.
// Throughput: one word per cycle unless the output stalls; the window update (one tap
// read of the zero chain, one subtract and one compare) completes in the accepting cycle.
// The zero positions live in a chain of FLIP_LIMIT cells; a new zero shifts the chain
// and the k-th newest old zero gives the new window start when the window is full.
// Reset clears the stream registers and the output valid flag, and sets max_flips to 1.
// A stream of more than 2^INDEX_BITS-1 bits raises the overflow flag until tlast.
// When the receiver stalls, the result holds in the output register and s_axis_tready
// stays high only if that register is being emptied in the same cycle.
`timescale 1ns / 1ps
`default_nettype none
`include "max_ones_run_with_flips_unit_assert.svh"
module max_ones_run_with_flips_unit
  import morf_pkg::*;
#(
  parameter int FLIP_LIMIT = FLIP_LIMIT_DEF,
  parameter int INDEX_BITS = INDEX_BITS_DEF
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  // config write channel
  input  wire logic             cfg_valid_i,
  output logic                  cfg_ready_o,
  input  wire logic [CFG_W-1:0] cfg_data_i,   // max_flips
  // input stream
  input  wire logic             s_axis_tvalid,
  output logic                  s_axis_tready,
  input  wire logic [7:0]       s_axis_tdata,  // [0] bit_value, [7:1] zero
  input  wire logic             s_axis_tlast,  // end_of_stream
  // output stream
  output logic                  m_axis_tvalid,
  input  wire logic             m_axis_tready,
  output logic      [31:0]      m_axis_tdata,  // [15:0] best_length, [31:16] window_length
  output logic                  m_axis_tlast,  // final_result
  output logic                  m_axis_tuser   // index_overflow
);

  localparam int KW   = $clog2(FLIP_LIMIT + 1);
  localparam int SELW = (FLIP_LIMIT > 1) ? $clog2(FLIP_LIMIT) : 1;
  localparam int SW   = (INDEX_BITS > OUT_W) ? INDEX_BITS : OUT_W;

  logic [CFG_W-1:0]      max_flips_q;
  logic [INDEX_BITS-1:0] pos_q, pos_d;
  logic [INDEX_BITS-1:0] ws_q, ws_d;
  logic [INDEX_BITS-1:0] best_q, best_d;
  logic [KW-1:0]         zc_q, zc_d;
  logic                  ovf_q, ovf_d;

  logic                  out_valid_q, out_valid_d;
  logic [OUT_W-1:0]      out_best_q, out_wlen_q;
  logic                  out_last_q, out_ovf_q;

  logic                  acc_in;
  logic                  bit_in;
  logic                  at_limit;
  logic [KW-1:0]         k_eff;
  logic [INDEX_BITS-1:0] pos_inc;
  logic [INDEX_BITS-1:0] ws_new;
  logic [KW-1:0]         zc_new;
  logic [INDEX_BITS-1:0] best_new;
  logic [INDEX_BITS-1:0] wlen_v;
  logic                  ovf_new;
  logic                  shift;
  logic [INDEX_BITS-1:0] tap;
  logic [SW-1:0]         best_ext, wlen_ext;

  // handshakes
  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign acc_in        = s_axis_tvalid && s_axis_tready;
  assign bit_in        = s_axis_tdata[0];

  // max_flips capped at the chain depth
  assign k_eff = (32'(max_flips_q) > FLIP_LIMIT) ? KW'(FLIP_LIMIT) : KW'(max_flips_q);

  assign at_limit = (pos_q == {INDEX_BITS{1'b1}});
  assign pos_inc  = pos_q + 1'b1;
  assign shift    = acc_in && !at_limit && !bit_in && (k_eff != '0);

  // zero-position chain; tap is the k-th newest stored zero
  morf_chain #(
    .DEPTH(FLIP_LIMIT),
    .W    (INDEX_BITS)
  ) u_chain (
    .clk_i    (clk_i),
    .shift_i  (shift),
    .din_i    (pos_q),
    .tap_sel_i(SELW'(k_eff - 1'b1)),
    .tap_o    (tap)
  );

  // window update for the word being taken
  always_comb begin
    ws_new   = ws_q;
    zc_new   = zc_q;
    best_new = best_q;
    ovf_new  = ovf_q;
    wlen_v   = pos_q - ws_q;
    if (at_limit) begin
      ovf_new = 1'b1;
    end else begin
      if (!bit_in) begin
        if (k_eff == '0) begin
          ws_new = pos_inc;
          zc_new = '0;
        end else if (zc_q >= k_eff) begin
          ws_new = tap + 1'b1;
          zc_new = k_eff;
        end else begin
          zc_new = zc_q + 1'b1;
        end
      end
      wlen_v = pos_inc - ws_new;
      if (wlen_v > best_q) begin
        best_new = wlen_v;
      end
    end
  end

  // next stream state, cleared after the closing word
  always_comb begin
    pos_d  = pos_q;
    ws_d   = ws_q;
    zc_d   = zc_q;
    best_d = best_q;
    ovf_d  = ovf_q;
    if (acc_in) begin
      if (s_axis_tlast) begin
        pos_d  = '0;
        ws_d   = '0;
        zc_d   = '0;
        best_d = '0;
        ovf_d  = 1'b0;
      end else begin
        pos_d  = at_limit ? pos_q : pos_inc;
        ws_d   = ws_new;
        zc_d   = zc_new;
        best_d = best_new;
        ovf_d  = ovf_new;
      end
    end
  end

  // output valid
  always_comb begin
    out_valid_d = out_valid_q;
    if (acc_in) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  // widen lengths for the saturation to 16 bits in the result payload
  assign best_ext = SW'(best_new);
  assign wlen_ext = SW'(wlen_v);

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_flips_q <= MAX_FLIPS_RST;
      pos_q       <= '0;
      ws_q        <= '0;
      zc_q        <= '0;
      best_q      <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        max_flips_q <= cfg_data_i;
      end
      pos_q       <= pos_d;
      ws_q        <= ws_d;
      zc_q        <= zc_d;
      best_q      <= best_d;
      ovf_q       <= ovf_d;
      out_valid_q <= out_valid_d;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (acc_in) begin
      out_best_q <= (best_ext > SW'(OUT_MAX)) ? OUT_W'(OUT_MAX) : best_ext[OUT_W-1:0];
      out_wlen_q <= (wlen_ext > SW'(OUT_MAX)) ? OUT_W'(OUT_MAX) : wlen_ext[OUT_W-1:0];
      out_last_q <= s_axis_tlast;
      out_ovf_q  <= ovf_new;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_wlen_q, out_best_q};
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tuser  = out_ovf_q;

  // checks
  `MORF_ASSERT_IMP(a_zc_bound, clk_i, rst_ni, 1'b1, 32'(zc_q) <= FLIP_LIMIT)
  `MORF_ASSERT_IMP(a_ws_le_pos, clk_i, rst_ni, 1'b1, ws_q <= pos_q)
  `MORF_ASSERT_IMP(a_ovf_at_limit, clk_i, rst_ni, ovf_q, pos_q == {INDEX_BITS{1'b1}})
  `MORF_ASSERT_NXT(a_last_clears, clk_i, rst_ni, acc_in && s_axis_tlast,
                   pos_q == '0 && zc_q == '0 && !ovf_q)
  `MORF_ASSERT_NXT(a_result_follows, clk_i, rst_ni, acc_in, m_axis_tvalid)

endmodule : max_ones_run_with_flips_unit
`default_nettype wire
